FILE: src/tbc512_pkg.sv
// shared types, constants and round functions for the threefish-512 pipeline
`timescale 1ns / 1ps
`default_nettype none
package tbc512_pkg;

	localparam logic [63:0] C240 = 64'h1BD11BDAA9FC1A22;

	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_TWEAK = 2'd1;
	localparam logic [1:0] KIND_BLOCK = 2'd2;

	typedef logic [7:0][63:0] block_t;
	typedef logic [8:0][63:0] ext_key_t;
	typedef logic [2:0][63:0] ext_tweak_t;

	// key schedule snapshot that travels with each block
	typedef struct packed {
		ext_key_t   ek;
		ext_tweak_t et;
		logic       decrypt;
	} sched_t;

	// rotation amount by round mod 8 and mix index
	function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [1:0] j);
		logic [5:0] a;
		a = 6'd0;
		case ({r, j})
			5'd0: a = 6'd46; 5'd1: a = 6'd36; 5'd2: a = 6'd19; 5'd3: a = 6'd37;
			5'd4: a = 6'd33; 5'd5: a = 6'd27; 5'd6: a = 6'd14; 5'd7: a = 6'd42;
			5'd8: a = 6'd17; 5'd9: a = 6'd49; 5'd10: a = 6'd36; 5'd11: a = 6'd39;
			5'd12: a = 6'd44; 5'd13: a = 6'd9; 5'd14: a = 6'd54; 5'd15: a = 6'd56;
			5'd16: a = 6'd39; 5'd17: a = 6'd30; 5'd18: a = 6'd34; 5'd19: a = 6'd24;
			5'd20: a = 6'd13; 5'd21: a = 6'd50; 5'd22: a = 6'd10; 5'd23: a = 6'd17;
			5'd24: a = 6'd25; 5'd25: a = 6'd29; 5'd26: a = 6'd39; 5'd27: a = 6'd43;
			5'd28: a = 6'd8; 5'd29: a = 6'd35; 5'd30: a = 6'd56; 5'd31: a = 6'd22;
			default: a = 6'd0;
		endcase
		return a;
	endfunction

	// subkey number s, all eight words
	function automatic block_t subkey(input sched_t k, input logic [4:0] s);
		block_t w;
		logic [3:0] idx;
		logic [1:0] t0;
		logic [1:0] t1;
		w = '0;
		t0 = 2'(s % 3);
		t1 = 2'((s + 5'd1) % 3);
		for (int i = 0; i < 8; i++) begin
			idx = 4'((s + 5'(i)) % 9);
			w[i] = k.ek[idx];
		end
		w[5] = w[5] + k.et[t0];
		w[6] = w[6] + k.et[t1];
		w[7] = w[7] + 64'(s);
		return w;
	endfunction

	function automatic block_t add_block(input block_t a, input block_t b);
		block_t o;
		for (int i = 0; i < 8; i++) o[i] = a[i] + b[i];
		return o;
	endfunction

	function automatic block_t sub_block(input block_t a, input block_t b);
		block_t o;
		for (int i = 0; i < 8; i++) o[i] = a[i] - b[i];
		return o;
	endfunction

	// one forward round: mix then permute
	function automatic block_t enc_round(input block_t v, input logic [2:0] r);
		block_t m;
		logic [63:0] x;
		logic [5:0] n;
		for (int j = 0; j < 4; j++) begin
			n = rot_amt(r, 2'(j));
			m[2*j] = v[2*j] + v[2*j+1];
			x = v[2*j+1];
			m[2*j+1] = ((x << n) | (x >> (7'd64 - 7'(n)))) ^ m[2*j];
		end
		return {m[3], m[0], m[5], m[6], m[7], m[4], m[1], m[2]};
	endfunction

	// one inverse round: unpermute then unmix
	function automatic block_t dec_round(input block_t v, input logic [2:0] r);
		block_t p;
		block_t o;
		logic [63:0] x;
		logic [5:0] n;
		p = {v[3], v[4], v[5], v[2], v[7], v[0], v[1], v[6]};
		for (int j = 0; j < 4; j++) begin
			n = rot_amt(r, 2'(j));
			x = p[2*j+1] ^ p[2*j];
			o[2*j+1] = (x >> n) | (x << (7'd64 - 7'(n)));
			o[2*j] = p[2*j] - o[2*j+1];
		end
		return o;
	endfunction

endpackage
`default_nettype wire

FILE: src/tbc512_stage.sv
// one pipeline stage: one round of either direction plus subkey add or subtract on rounds that take a subkey
`timescale 1ns / 1ps
`default_nettype none
module tbc512_stage #(
	parameter int ROUNDS = 72,
	parameter int IDX    = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    adv,
	input  wire                    in_valid,
	input  tbc512_pkg::block_t     in_data,
	input  tbc512_pkg::sched_t     in_sched,
	output logic                   out_valid,
	output tbc512_pkg::block_t     out_data,
	output tbc512_pkg::sched_t     out_sched
);
	// encrypt runs round IDX, decrypt runs round ROUNDS-1-IDX
	localparam int ER = IDX;
	localparam int DR = ROUNDS - 1 - IDX;
	localparam logic [2:0] ER_MOD = 3'(ER % 8);
	localparam logic [2:0] DR_MOD = 3'(DR % 8);
	localparam logic [4:0] ES = 5'(ER / 4);
	localparam logic [4:0] DS = 5'(DR / 4);
	localparam bit E_INJ = (ER % 4) == 0;
	localparam bit D_INJ = (DR % 4) == 0;

	tbc512_pkg::block_t enc_in;
	tbc512_pkg::block_t enc_out;
	tbc512_pkg::block_t dec_mid;
	tbc512_pkg::block_t dec_out;
	tbc512_pkg::block_t result;

	// forward: subkey then round; inverse: round then subkey subtract; decrypt bit selects
	always_comb begin
		enc_in = E_INJ ? tbc512_pkg::add_block(in_data, tbc512_pkg::subkey(in_sched, ES))
			: in_data;
		enc_out = tbc512_pkg::enc_round(enc_in, ER_MOD);
		dec_mid = tbc512_pkg::dec_round(in_data, DR_MOD);
		dec_out = D_INJ ? tbc512_pkg::sub_block(dec_mid, tbc512_pkg::subkey(in_sched, DS))
			: dec_mid;
		result = in_sched.decrypt ? dec_out : enc_out;
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data  <= result;
			out_sched <= in_sched;
		end
	end
endmodule
`default_nettype wire

FILE: src/tweakable_block_cipher_512.sv
// top level: mode, key and tweak registers, round pipeline and output register
//
// channel   dir  beat contents
// s_axis    in   tuser = kind, tdata = word 0..7 (64 bits each)
// m_axis    out  tdata = out_word 0..7 (64 bits each)
// cfg       in   cfg_we / cfg_wdata[0] = decrypt_mode
//
// one block per cycle while the output is not stalled; stages: entry stage,
// one stage per round, exit stage. key and tweak beats give no output and
// apply to blocks accepted after them. reset clears valid bits and mode
// only. the whole pipeline advances when the output register is free or
// being taken, so a stall holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none
module tweakable_block_cipher_512 #(
	parameter int ROUNDS = 72
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [511:0] s_axis_tdata,   // in_word_0 .. in_word_7
	input  wire  [1:0]   s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [511:0] m_axis_tdata,   // out_word_0 .. out_word_7
	input  wire          cfg_we,
	input  wire          cfg_wdata
);
	localparam logic [4:0] FINAL_S = 5'((ROUNDS + 3) / 4);

	logic [7:0][63:0] key_q;
	logic [1:0][63:0] tweak_q;
	logic             decrypt_q;
	logic             adv;
	logic             take;
	tbc512_pkg::sched_t sched;

	logic               v_s [0:ROUNDS];
	tbc512_pkg::block_t d_s [0:ROUNDS];
	tbc512_pkg::sched_t k_s [0:ROUNDS];
	tbc512_pkg::block_t in_blk;

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign take = s_axis_tvalid && s_axis_tready;
	assign in_blk = s_axis_tdata;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
		end else if (cfg_we) begin
			decrypt_q <= cfg_wdata;
		end
	end

	// key and tweak storage
	always_ff @(posedge clk) begin
		if (take && s_axis_tuser == tbc512_pkg::KIND_KEY) begin
			key_q <= s_axis_tdata;
		end
		if (take && s_axis_tuser == tbc512_pkg::KIND_TWEAK) begin
			tweak_q <= s_axis_tdata[127:0];
		end
	end

	// extended key and tweak
	always_comb begin
		sched.ek[8] = tbc512_pkg::C240;
		for (int i = 0; i < 8; i++) begin
			sched.ek[i] = key_q[i];
			sched.ek[8] = sched.ek[8] ^ key_q[i];
		end
		sched.et = {tweak_q[0] ^ tweak_q[1], tweak_q[1], tweak_q[0]};
		sched.decrypt = decrypt_q;
	end

	// entry stage: decrypt removes the final subkey here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= take && s_axis_tuser == tbc512_pkg::KIND_BLOCK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0] <= decrypt_q ?
				tbc512_pkg::sub_block(in_blk, tbc512_pkg::subkey(sched, FINAL_S)) : in_blk;
			k_s[0] <= sched;
		end
	end

	// round stages
	for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
		tbc512_stage #(.ROUNDS(ROUNDS), .IDX(g)) u_stage (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.in_valid(v_s[g]), .in_data(d_s[g]), .in_sched(k_s[g]),
			.out_valid(v_s[g+1]), .out_data(d_s[g+1]), .out_sched(k_s[g+1])
		);
	end

	// exit stage: encrypt adds the final subkey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= v_s[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= k_s[ROUNDS].decrypt ? d_s[ROUNDS] :
				tbc512_pkg::add_block(d_s[ROUNDS], tbc512_pkg::subkey(k_s[ROUNDS], FINAL_S));
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed during stall");
	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline stalled");
	a_key_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		take && s_axis_tuser != tbc512_pkg::KIND_BLOCK |=> !v_s[0])
		else $error("non-block beat entered pipeline");
	a_first_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s[0]) && $stable(v_s[ROUNDS]))
		else $error("stage valid moved during stall");
`endif
endmodule
`default_nettype wire
